// File: hdl/wdt_pkg.sv
// Shared types, constants and helpers for the watchdog timer peripheral.
// No dependencies; imported by every module of the block.
package wdt_pkg;

    localparam int COUNT_WIDTH    = 16;
    localparam int PRESCALE_WIDTH = 8;
    localparam int BUS_WIDTH      = 16;
    localparam int DIV_WIDTH      = 7;

    // Item kinds
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Register map
    localparam logic [1:0] REG_CTRL    = 2'd0;
    localparam logic [1:0] REG_RELOAD  = 2'd1;
    localparam logic [1:0] REG_COUNT   = 2'd2;
    localparam logic [1:0] REG_IRQ_CLR = 2'd3;

    // Control register bits
    localparam int CTRL_RST_EN_BIT = 0;
    localparam int CTRL_IRQ_EN_BIT = 2;
    localparam int CTRL_DIV_LSB    = 3;
    localparam int CTRL_ENABLE_BIT = 5;
    localparam int CTRL_PRE_LSB    = 8;

    localparam logic [BUS_WIDTH-1:0] CTRL_RESET  = 16'h8021;
    localparam logic [31:0]          COUNT_RESET = 32'h0000_8000;

    typedef logic [COUNT_WIDTH-1:0]    t_count;
    typedef logic [PRESCALE_WIDTH-1:0] t_pre;
    typedef logic [DIV_WIDTH-1:0]      t_div;
    typedef logic [BUS_WIDTH-1:0]      t_bus;

    // Timer controls handed from the register file to the divider chain
    typedef struct packed {
        logic       enable;
        t_pre       pre;
        logic [1:0] div_sel;
    } t_ctrl;

    // Bus data into a count-wide register
    function automatic t_count bus_to_count(input t_bus d);
        logic [31:0] tmp;
        tmp = 32'(d);
        return tmp[COUNT_WIDTH-1:0];
    endfunction

    // Count-wide register onto the bus (low bits)
    function automatic t_bus count_to_bus(input t_count c);
        logic [31:0] tmp;
        tmp = 32'(c);
        return tmp[BUS_WIDTH-1:0];
    endfunction

    // Terminal value of the divider stage: 15, 31, 63 or 127
    function automatic t_div div_last(input logic [1:0] sel);
        t_div res;
        case (sel)
            2'd0:    res = 7'd15;
            2'd1:    res = 7'd31;
            2'd2:    res = 7'd63;
            default: res = 7'd127;
        endcase
        return res;
    endfunction

endpackage

// File: hdl/watchdog_timer_peripheral_unit.sv
// Watchdog timer peripheral: prescaler, divider, reloading down counter.
// Each result is registered in the output stage, or in skid if it stalls.
// Throughput: one item per cycle if skid free; all state updates on accept.
// A skid register keeps input ready while one result waits at the output.
// Reset (i_rst_n, synchronous, active low) loads control 0x8021, reload and
// count 0x8000, clears both stage counters, the irq flag and output valids.
module watchdog_timer_peripheral_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_mode,
    input  logic [1:0]          i_reg_select,
    input  wdt_pkg::t_bus       i_write_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wdt_pkg::t_bus       o_read_data,
    output logic                o_irq_pending,
    output logic                o_reset_pulse
);
    import wdt_pkg::*;

    logic   accept, tick, div_tick, take;
    t_ctrl  ctrl;
    t_bus   res_rdata;
    logic   res_irq, res_rst;

    // Output stage and skid stage
    logic   r_out_valid, r_skid_valid;
    t_bus   r_out_rdata, r_skid_rdata;
    logic   r_out_irq,   r_skid_irq;
    logic   r_out_rst,   r_skid_rst;

    // Hold off new transfers only while the skid stage is occupied
    assign o_in_ready = !r_skid_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign take       = r_out_valid && i_out_ready;
    assign tick       = accept && (i_mode == MODE_TICK);

    // Prescaler and divider: produce the tick that moves the counter
    wdt_divchain u_divchain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (tick),
        .i_ctrl     (ctrl),
        .o_div_tick (div_tick)
    );

    // Registers, down counter, irq flag; result computed for this item
    wdt_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_mode        (i_mode),
        .i_reg_select  (i_reg_select),
        .i_write_data  (i_write_data),
        .i_div_tick    (div_tick),
        .o_ctrl        (ctrl),
        .o_read_data   (res_rdata),
        .o_irq_pending (res_irq),
        .o_reset_pulse (res_rst)
    );

    // Control of the output and skid valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (r_skid_valid) begin
                // Advance the skid entry once the output drains
                if (take) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end
            end else if (accept) begin
                // Park the new result in skid if output is stuck
                if (r_out_valid && !take) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end else if (take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output and skid stages
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (take) begin
                r_out_rdata <= r_skid_rdata;
                r_out_irq   <= r_skid_irq;
                r_out_rst   <= r_skid_rst;
            end
        end else if (accept) begin
            if (r_out_valid && !take) begin
                r_skid_rdata <= res_rdata;
                r_skid_irq   <= res_irq;
                r_skid_rst   <= res_rst;
            end else begin
                r_out_rdata <= res_rdata;
                r_out_irq   <= res_irq;
                r_out_rst   <= res_rst;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out_rdata;
    assign o_irq_pending = r_out_irq;
    assign o_reset_pulse = r_out_rst;

endmodule

// File: hdl/wdt_divchain.sv
// Prescaler and selectable divider stage of the watchdog timer.
// Depends on wdt_pkg.
module wdt_divchain (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_tick,
    input  wdt_pkg::t_ctrl i_ctrl,
    output logic           o_div_tick
);
    import wdt_pkg::*;

    t_pre r_pre_cnt, n_pre_cnt;
    t_div r_div_cnt, n_div_cnt;
    logic active, pre_wrap, div_wrap;

    assign active     = i_tick && i_ctrl.enable;
    assign pre_wrap   = (r_pre_cnt >= i_ctrl.pre);
    assign div_wrap   = (r_div_cnt >= div_last(i_ctrl.div_sel));
    assign o_div_tick = active && pre_wrap && div_wrap;

    always_comb begin
        n_pre_cnt = r_pre_cnt;
        n_div_cnt = r_div_cnt;
        if (active) begin
            if (pre_wrap) begin
                n_pre_cnt = '0;
                n_div_cnt = div_wrap ? '0 : r_div_cnt + 1'b1;
            end else begin
                n_pre_cnt = r_pre_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_cnt <= '0;
            r_div_cnt <= '0;
        end else begin
            r_pre_cnt <= n_pre_cnt;
            r_div_cnt <= n_div_cnt;
        end
    end

endmodule

// File: hdl/wdt_regs.sv
// Register file, down counter and interrupt flag of the watchdog timer.
// Depends on wdt_pkg.
module wdt_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [1:0]     i_mode,
    input  logic [1:0]     i_reg_select,
    input  wdt_pkg::t_bus  i_write_data,
    input  logic           i_div_tick,
    output wdt_pkg::t_ctrl o_ctrl,
    output wdt_pkg::t_bus  o_read_data,
    output logic           o_irq_pending,
    output logic           o_reset_pulse
);
    import wdt_pkg::*;

    t_bus   r_ctrl,   n_ctrl;
    t_count r_reload, n_reload;
    t_count r_count,  n_count;
    logic   r_irq,    n_irq;
    logic   wr, rd, timeout;

    assign wr = i_accept && (i_mode == MODE_WRITE);
    assign rd = (i_mode == MODE_READ);

    assign o_ctrl.enable  = r_ctrl[CTRL_ENABLE_BIT];
    assign o_ctrl.pre     = r_ctrl[CTRL_PRE_LSB +: PRESCALE_WIDTH];
    assign o_ctrl.div_sel = r_ctrl[CTRL_DIV_LSB +: 2];

    // Divided tick with count at zero or one means timeout
    assign timeout = i_div_tick && (r_count <= t_count'(1));

    always_comb begin
        n_ctrl   = r_ctrl;
        n_reload = r_reload;
        n_count  = r_count;
        n_irq    = r_irq;
        if (i_div_tick) begin
            if (timeout) begin
                n_count = r_reload;
                if (r_ctrl[CTRL_IRQ_EN_BIT]) begin
                    n_irq = 1'b1;
                end
            end else begin
                n_count = r_count - 1'b1;
            end
        end
        if (wr) begin
            unique case (i_reg_select)
                REG_CTRL:    n_ctrl   = i_write_data;
                REG_RELOAD:  n_reload = bus_to_count(i_write_data);
                REG_COUNT:   n_count  = bus_to_count(i_write_data);
                REG_IRQ_CLR: n_irq    = 1'b0;
                default:     n_irq    = r_irq;
            endcase
        end
    end

    always_comb begin
        o_read_data = '0;
        if (rd) begin
            unique case (i_reg_select)
                REG_CTRL:   o_read_data = r_ctrl;
                REG_RELOAD: o_read_data = count_to_bus(r_reload);
                REG_COUNT:  o_read_data = count_to_bus(r_count);
                default:    o_read_data = '0;
            endcase
        end
    end

    assign o_irq_pending = n_irq;
    assign o_reset_pulse = timeout && r_ctrl[CTRL_RST_EN_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= CTRL_RESET;
            r_reload <= COUNT_RESET[COUNT_WIDTH-1:0];
            r_count  <= COUNT_RESET[COUNT_WIDTH-1:0];
            r_irq    <= 1'b0;
        end else if (i_accept) begin
            r_ctrl   <= n_ctrl;
            r_reload <= n_reload;
            r_count  <= n_count;
            r_irq    <= n_irq;
        end
    end

endmodule
